/* design/fsmp_pkg.sv */
// ----------------------------------------------------------------------------
// fsmp_pkg
// shared types and constants of the five-stage mips subset pipeline
// ----------------------------------------------------------------------------
package fsmp_pkg;

  localparam int unsigned INSTR_WORDS_DEF = 256;
  localparam int unsigned DATA_WORDS_DEF  = 256;

  // instruction encodings
  localparam logic [5:0] OPC_RTYPE = 6'b000000;
  localparam logic [5:0] OPC_LW    = 6'b100011;
  localparam logic [5:0] OPC_SW    = 6'b101011;
  localparam logic [5:0] OPC_BR    = 6'b000100;
  localparam logic [5:0] FN_ADDU   = 6'b100001;

  localparam logic [31:0] HALT_WORD = 32'hFFFF_FFFF;

  // word kinds on the input channel
  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_LOAD_INSTR = 3'd1,
    OP_LOAD_DATA  = 3'd2,
    OP_LOAD_REG   = 3'd3,
    OP_READ_REG   = 3'd4,
    OP_READ_DATA  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_REG,
    RD_DATA
  } rd_kind_e;

  // result word, first field in the highest bits
  typedef struct packed {
    logic [31:0] read_value;
    logic [31:0] store_value;
    logic [31:0] store_addr;
    logic        store_valid;
    logic [31:0] wb_value;
    logic [4:0]  wb_reg;
    logic        wb_valid;
    logic        finished;
    logic [31:0] fetch_pc;
  } result_t;

  function automatic logic [31:0] sext16(input logic [15:0] v);
    sext16 = {{16{v[15]}}, v};
  endfunction

endpackage

/* design/five_stage_mips_pipeline_core.sv */
// ----------------------------------------------------------------------------
// five_stage_mips_pipeline_core
// mips subset core: fetch, decode, execute, memory, writeback, no forwarding
// ----------------------------------------------------------------------------
// usage:
//   input channel (s_axis): one word per command. tuser holds the kind
//   (tick, load instruction, load data, load register, read register,
//   read data); tdata holds the word index and the load value.
//   a tick advances all five pipeline stages by one step.
//   output channel (m_axis): exactly one result word per input word, in
//   order: fetch pc, finished flag, writeback and store reports of the
//   tick, and the read value of the read kinds.
//   throughput: one input word per clock while the output queue has room.
//   the result is registered in the read-out stage (for the registered
//   memory reads) and then in the output queue.
//   instruction, data and register contents live in synchronous rams; the
//   words a tick needs are read ahead from the next pc, the next decode
//   word and the next memory-stage address, with bypass on writes.
//   reset: pc and all stage valid flags clear; then a clearing pass over
//   max(DATA_WORDS, 32) words zeroes data memory and the register file,
//   during which s_axis_tready stays low.
//   stall: a three-entry output queue keeps input flowing while m_axis is
//   stalled; s_axis_tready drops only when the queue would overflow.
//   memory depths must be powers of two; the block does not enforce this.
// ----------------------------------------------------------------------------
module five_stage_mips_pipeline_core
  import fsmp_pkg::*;
#(
  parameter int unsigned INSTR_WORDS = INSTR_WORDS_DEF,
  parameter int unsigned DATA_WORDS  = DATA_WORDS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,   // word_index[7:0], load_value[39:8]
  input  logic [2:0]   s_axis_tuser,   // op[2:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [167:0] m_axis_tdata    // fetch_pc, finished, wb_valid, wb_reg,
                                       // wb_value, store_valid, store_addr,
                                       // store_value, read_value
);

  localparam int unsigned IW = $clog2(INSTR_WORDS);
  localparam int unsigned DW = $clog2(DATA_WORDS);
  localparam int unsigned CLR_WORDS = (DATA_WORDS > 32) ? DATA_WORDS : 32;
  localparam int unsigned CW = $clog2(CLR_WORDS + 1);

  // input word fields
  op_e         op;
  logic [7:0]  word_index;
  logic [31:0] load_value;
  logic        acc, tick_go, clearing;

  assign op         = op_e'(s_axis_tuser);
  assign word_index = s_axis_tdata[7:0];
  assign load_value = s_axis_tdata[39:8];

  // clearing pass after reset
  logic [CW-1:0] clr_q, clr_d;
  assign clearing = (clr_q != CW'(CLR_WORDS));
  assign clr_d    = clearing ? clr_q + CW'(1) : clr_q;

  // pipeline state
  logic [31:0] pc_q, pc_d;
  logic        idle_q, idle_d;
  logic        d_v_q, d_v_d;
  logic [31:0] d_ins_q, d_ins_d;
  logic        e_v_q, e_isi_q, e_rd_q, e_wr_q, e_add_q, e_wen_q;
  logic        e_v_d, e_isi_d, e_rd_d, e_wr_d, e_add_d, e_wen_d;
  logic [31:0] e_a_q, e_b_q, e_a_d, e_b_d;
  logic [15:0] e_imm_q, e_imm_d;
  logic [4:0]  e_wreg_q, e_wreg_d;
  logic        m_v_q, m_rd_q, m_wr_q, m_wen_q, m_v_d, m_rd_d, m_wr_d, m_wen_d;
  logic [31:0] m_alu_q, m_st_q, m_alu_d, m_st_d;
  logic [4:0]  m_wreg_q, m_wreg_d;
  logic        w_v_q, w_wen_q, w_v_d, w_wen_d;
  logic [31:0] w_val_q, w_val_d;
  logic [4:0]  w_reg_q, w_reg_d;
  logic        all_empty_q;

  assign all_empty_q = idle_q && !d_v_q && !e_v_q && !m_v_q && !w_v_q;

  // ram ports
  logic          im_we;
  logic [IW-1:0] im_waddr, im_raddr;
  logic [31:0]   im_rdata;
  logic          rf_we;
  logic [4:0]    rf_waddr, rs_raddr, rt_raddr, rr_raddr;
  logic [31:0]   rf_wdata, rs_rdata, rt_rdata, rr_rdata;
  logic          dm_we;
  logic [DW-1:0] dm_waddr, dm_raddr, dr_raddr;
  logic [31:0]   dm_wdata, dm_rdata, dr_rdata;

  // bypass for writes that hit an entry read at the same edge
  logic        im_byp_q, rs_byp_q, rt_byp_q, dm_byp_q;
  logic [31:0] im_bdat_q, rs_bdat_q, rt_bdat_q, dm_bdat_q;

  // read-out stage and output queue
  logic        r1_v_q;
  result_t     r1_q, r1_d;
  rd_kind_e    r1_kind_q, r1_kind_d;
  logic        r1_zero_q, r1_zero_d;
  result_t     fifo_q [3];
  result_t     push_word;
  logic [1:0]  wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        pop;

  // tick datapath signals
  logic [31:0] ins_word, dm_word, rs_val, rt_val, alu_b, br_pc;
  logic [5:0]  opc;
  logic [4:0]  rs, rt, rd;
  logic        branch, wb_fire;

  assign s_axis_tready = !clearing && ({1'b0, cnt_q} + {2'b00, r1_v_q} < 3'd3);
  assign acc     = s_axis_tvalid && s_axis_tready;
  assign tick_go = acc && (op == OP_TICK) && !all_empty_q;
  assign wb_fire = w_v_q && w_wen_q;

  // effective read data of the look-ahead ports
  assign ins_word = im_byp_q ? im_bdat_q : im_rdata;
  assign dm_word  = dm_byp_q ? dm_bdat_q : dm_rdata;

  // one tick of all five stages
  always_comb begin
    opc    = d_ins_q[31:26];
    rs     = d_ins_q[25:21];
    rt     = d_ins_q[20:16];
    rd     = d_ins_q[15:11];
    // writeback lands before the decode read
    if (rs == 5'd0) begin
      rs_val = '0;
    end else if (wb_fire && w_reg_q == rs) begin
      rs_val = w_val_q;
    end else begin
      rs_val = rs_byp_q ? rs_bdat_q : rs_rdata;
    end
    if (rt == 5'd0) begin
      rt_val = '0;
    end else if (wb_fire && w_reg_q == rt) begin
      rt_val = w_val_q;
    end else begin
      rt_val = rt_byp_q ? rt_bdat_q : rt_rdata;
    end
    branch = d_v_q && (opc == OPC_BR) && (rs_val != rt_val);
    br_pc  = pc_q + (sext16(d_ins_q[15:0]) << 2);
    alu_b  = e_isi_q ? sext16(e_imm_q) : e_b_q;

    pc_d = pc_q; idle_d = idle_q; d_v_d = d_v_q; d_ins_d = d_ins_q;
    e_v_d = e_v_q; e_isi_d = e_isi_q; e_rd_d = e_rd_q; e_wr_d = e_wr_q;
    e_add_d = e_add_q; e_wen_d = e_wen_q; e_a_d = e_a_q; e_b_d = e_b_q;
    e_imm_d = e_imm_q; e_wreg_d = e_wreg_q;
    m_v_d = m_v_q; m_rd_d = m_rd_q; m_wr_d = m_wr_q; m_wen_d = m_wen_q;
    m_alu_d = m_alu_q; m_st_d = m_st_q; m_wreg_d = m_wreg_q;
    w_v_d = w_v_q; w_wen_d = w_wen_q; w_val_d = w_val_q; w_reg_d = w_reg_q;

    if (tick_go) begin
      // memory
      w_v_d = m_v_q;
      if (m_v_q) begin
        w_val_d = m_rd_q ? dm_word : m_alu_q;
        w_reg_d = m_wreg_q;
        w_wen_d = m_wen_q;
      end
      // execute
      m_v_d = e_v_q;
      if (e_v_q) begin
        m_alu_d  = e_add_q ? e_a_q + alu_b : e_a_q - alu_b;
        m_st_d   = e_b_q;
        m_wreg_d = e_wreg_q;
        m_rd_d   = e_rd_q;
        m_wr_d   = e_wr_q;
        m_wen_d  = e_wen_q;
      end
      // decode
      e_v_d = d_v_q;
      if (d_v_q) begin
        e_isi_d  = (opc != OPC_RTYPE);
        e_rd_d   = (opc == OPC_LW);
        e_wr_d   = (opc == OPC_SW);
        e_a_d    = rs_val;
        e_b_d    = rt_val;
        e_imm_d  = d_ins_q[15:0];
        e_wreg_d = (opc != OPC_RTYPE) ? rt : rd;
        e_add_d  = (d_ins_q[5:0] == FN_ADDU) || (opc == OPC_LW) || (opc == OPC_SW);
        e_wen_d  = (opc == OPC_RTYPE) || (opc == OPC_LW);
      end
      // fetch; a halt wins over a taken branch
      d_v_d = 1'b0;
      if (branch) begin
        pc_d = br_pc;
      end
      if (!idle_q) begin
        if (ins_word == HALT_WORD) begin
          idle_d = 1'b1;
          pc_d   = pc_q;
        end else begin
          d_v_d   = 1'b1;
          d_ins_d = ins_word;
          if (!branch) begin
            pc_d = pc_q + 32'd4;
          end
        end
      end
    end
  end

  // ram write ports
  always_comb begin
    im_we    = acc && (op == OP_LOAD_INSTR);
    im_waddr = IW'(word_index);

    rf_we    = 1'b0;
    rf_waddr = word_index[4:0];
    rf_wdata = load_value;
    priority if (clearing) begin
      rf_we    = 1'b1;
      rf_waddr = 5'(clr_q);
      rf_wdata = '0;
    end else if (tick_go && wb_fire && w_reg_q != 5'd0) begin
      rf_we    = 1'b1;
      rf_waddr = w_reg_q;
      rf_wdata = w_val_q;
    end else if (acc && op == OP_LOAD_REG && word_index[4:0] != 5'd0) begin
      rf_we = 1'b1;
    end else begin
      rf_we = 1'b0;
    end

    dm_we    = 1'b0;
    dm_waddr = DW'(word_index);
    dm_wdata = load_value;
    priority if (clearing) begin
      dm_we    = 1'b1;
      dm_waddr = DW'(clr_q);
      dm_wdata = '0;
    end else if (tick_go && m_v_q && m_wr_q) begin
      dm_we    = 1'b1;
      dm_waddr = m_alu_q[DW+1:2];
      dm_wdata = m_st_q;
    end else if (acc && op == OP_LOAD_DATA) begin
      dm_we = 1'b1;
    end else begin
      dm_we = 1'b0;
    end
  end

  // look-ahead read addresses from the next state
  assign im_raddr = pc_d[IW+1:2];
  assign rs_raddr = d_ins_d[25:21];
  assign rt_raddr = d_ins_d[20:16];
  assign dm_raddr = m_alu_d[DW+1:2];
  assign rr_raddr = word_index[4:0];
  assign dr_raddr = DW'(word_index);

  fsmp_ram #(.WIDTH(32), .DEPTH(INSTR_WORDS)) u_imem (
    .clk_i, .we_i(im_we), .waddr_i(im_waddr), .wdata_i(load_value),
    .raddr_i(im_raddr), .rdata_o(im_rdata)
  );
  fsmp_ram #(.WIDTH(32), .DEPTH(32)) u_rf_rs (
    .clk_i, .we_i(rf_we), .waddr_i(rf_waddr), .wdata_i(rf_wdata),
    .raddr_i(rs_raddr), .rdata_o(rs_rdata)
  );
  fsmp_ram #(.WIDTH(32), .DEPTH(32)) u_rf_rt (
    .clk_i, .we_i(rf_we), .waddr_i(rf_waddr), .wdata_i(rf_wdata),
    .raddr_i(rt_raddr), .rdata_o(rt_rdata)
  );
  fsmp_ram #(.WIDTH(32), .DEPTH(32)) u_rf_rd (
    .clk_i, .we_i(rf_we), .waddr_i(rf_waddr), .wdata_i(rf_wdata),
    .raddr_i(rr_raddr), .rdata_o(rr_rdata)
  );
  fsmp_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dmem (
    .clk_i, .we_i(dm_we), .waddr_i(dm_waddr), .wdata_i(dm_wdata),
    .raddr_i(dm_raddr), .rdata_o(dm_rdata)
  );
  fsmp_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dmem_rd (
    .clk_i, .we_i(dm_we), .waddr_i(dm_waddr), .wdata_i(dm_wdata),
    .raddr_i(dr_raddr), .rdata_o(dr_rdata)
  );

  // result of the accepted word, read value filled in the cycle after
  always_comb begin
    r1_d             = '0;
    r1_d.fetch_pc    = pc_d;
    r1_d.finished    = idle_d && !d_v_d && !e_v_d && !m_v_d && !w_v_d;
    r1_d.wb_valid    = tick_go && wb_fire;
    r1_d.wb_reg      = (tick_go && wb_fire) ? w_reg_q : 5'd0;
    r1_d.wb_value    = (tick_go && wb_fire) ? w_val_q : 32'd0;
    r1_d.store_valid = tick_go && m_v_q && m_wr_q;
    r1_d.store_addr  = (tick_go && m_v_q && m_wr_q) ? m_alu_q : 32'd0;
    r1_d.store_value = (tick_go && m_v_q && m_wr_q) ? m_st_q : 32'd0;
    r1_zero_d        = (word_index[4:0] == 5'd0);
    unique case (op)
      OP_READ_REG:  r1_kind_d = RD_REG;
      OP_READ_DATA: r1_kind_d = RD_DATA;
      default:      r1_kind_d = RD_NONE;
    endcase
  end

  always_comb begin
    push_word = r1_q;
    unique case (r1_kind_q)
      RD_REG:  push_word.read_value = r1_zero_q ? 32'd0 : rr_rdata;
      RD_DATA: push_word.read_value = dr_rdata;
      default: push_word.read_value = 32'd0;
    endcase
  end

  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = 168'(fifo_q[rd_ptr_q]);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q    <= '0;
      pc_q     <= '0;
      idle_q   <= 1'b0;
      d_v_q    <= 1'b0;
      e_v_q    <= 1'b0;
      m_v_q    <= 1'b0;
      w_v_q    <= 1'b0;
      r1_v_q   <= 1'b0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      im_byp_q <= 1'b0;
      rs_byp_q <= 1'b0;
      rt_byp_q <= 1'b0;
      dm_byp_q <= 1'b0;
    end else begin
      clr_q    <= clr_d;
      pc_q     <= pc_d;
      idle_q   <= idle_d;
      d_v_q    <= d_v_d;
      e_v_q    <= e_v_d;
      m_v_q    <= m_v_d;
      w_v_q    <= w_v_d;
      r1_v_q   <= acc;
      im_byp_q <= im_we && (im_waddr == im_raddr);
      rs_byp_q <= rf_we && (rf_waddr == rs_raddr);
      rt_byp_q <= rf_we && (rf_waddr == rt_raddr);
      dm_byp_q <= dm_we && (dm_waddr == dm_raddr);
      if (r1_v_q) begin
        wr_ptr_q <= (wr_ptr_q == 2'd2) ? 2'd0 : wr_ptr_q + 2'd1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == 2'd2) ? 2'd0 : rd_ptr_q + 2'd1;
      end
      cnt_q <= cnt_q + {1'b0, r1_v_q} - {1'b0, pop};
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    d_ins_q   <= d_ins_d;
    e_isi_q   <= e_isi_d;
    e_rd_q    <= e_rd_d;
    e_wr_q    <= e_wr_d;
    e_add_q   <= e_add_d;
    e_wen_q   <= e_wen_d;
    e_a_q     <= e_a_d;
    e_b_q     <= e_b_d;
    e_imm_q   <= e_imm_d;
    e_wreg_q  <= e_wreg_d;
    m_rd_q    <= m_rd_d;
    m_wr_q    <= m_wr_d;
    m_wen_q   <= m_wen_d;
    m_alu_q   <= m_alu_d;
    m_st_q    <= m_st_d;
    m_wreg_q  <= m_wreg_d;
    w_wen_q   <= w_wen_d;
    w_val_q   <= w_val_d;
    w_reg_q   <= w_reg_d;
    im_bdat_q <= load_value;
    rs_bdat_q <= rf_wdata;
    rt_bdat_q <= rf_wdata;
    dm_bdat_q <= dm_wdata;
    r1_q      <= r1_d;
    r1_kind_q <= r1_kind_d;
    r1_zero_q <= r1_zero_d;
    if (r1_v_q) begin
      fifo_q[wr_ptr_q] <= push_word;
    end
  end

endmodule

/* design/fsmp_ram.sv */
// ----------------------------------------------------------------------------
// fsmp_ram
// single-port-write ram with one registered read port (read-first)
// ----------------------------------------------------------------------------
module fsmp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
